>>> design/gpirn_pkg.sv
// ----------------------------------------------------------------------------
// gpirn_pkg: gamepad input report neutralizer package
// Byte positions and byte values used when a report is rewritten.
// ----------------------------------------------------------------------------
package gpirn_pkg;

  // Report selection
  localparam logic [7:0]  REPORT_TAG   = 8'h11;
  localparam int unsigned MIN_LENGTH   = 36;

  // Touch frame layout
  localparam int unsigned COUNT_POS    = 35;
  localparam int unsigned CONTACT_A    = 37;
  localparam int unsigned CONTACT_B    = 41;
  localparam int unsigned FRAME_STRIDE = 9;

  // Fixed byte positions
  localparam int unsigned STICK_FIRST  = 3;
  localparam int unsigned STICK_LAST   = 6;
  localparam int unsigned HAT_POS      = 7;
  localparam int unsigned BTN_HI_POS   = 8;
  localparam int unsigned BTN_LO_POS   = 9;
  localparam int unsigned TRIG_L_POS   = 10;
  localparam int unsigned TRIG_R_POS   = 11;
  localparam int unsigned GYRO_FIRST   = 15;
  localparam int unsigned GYRO_LAST    = 20;

  // Byte values
  localparam logic [7:0]  STICK_CENTER = 8'h80;
  localparam logic [7:0]  HAT_NEUTRAL  = 8'h08;
  localparam logic [7:0]  BTN_KEEP     = 8'hfc;
  localparam logic [7:0]  LIFT_BIT     = 8'h80;
  localparam logic [7:0]  BYTE_ZERO    = 8'h00;

endpackage

>>> design/gamepad_input_report_neutralizer.sv
// ----------------------------------------------------------------------------
// gamepad_input_report_neutralizer
// Rewrites a gamepad input report, one byte per item, to show a pad at rest.
// ----------------------------------------------------------------------------
// Timing: an accepted item passes the input register and then the result
//   register; out_valid rises when the item reaches the result register.
//   Throughput: one item per cycle, sustained, with no bubbles, while out_stall is low.
// The per-byte work is a position compare against a few constants and a byte
//   mux, all between the input register and the result register.
// Reset (rst_n low, synchronous): both stages empty, position and length 0,
//   rewrite off, touch frame count 0; bytes before a first byte pass through.
// ----------------------------------------------------------------------------
module gamepad_input_report_neutralizer
  import gpirn_pkg::*;
#(
  parameter int MAX_TOUCH_FRAMES = 4,
  parameter int LENGTH_BITS      = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,

  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_first_byte,
  input  logic [LENGTH_BITS-1:0] in_report_length,

  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte
);

  // touch frame count holds 0..MAX_TOUCH_FRAMES
  localparam int TW = $clog2(MAX_TOUCH_FRAMES + 1);
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                   s1_valid_r;
  logic [7:0]             s1_data_r;
  logic                   s1_first_r;
  logic [LENGTH_BITS-1:0] s1_len_r;

  logic                   in_accept;
  logic                   s1_adv;   // stage 1 item moves into the result register

  // Result register is free when empty or being drained this cycle.
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_len_r   <= in_report_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Report state, updated as each item leaves stage 1
  // ---------------------------------------------------------------------------
  logic [LENGTH_BITS-1:0] byte_position_r, byte_position_nxt;
  logic                   rewrite_active_r, rewrite_active_nxt;
  logic [LENGTH_BITS-1:0] held_length_r, held_length_nxt;
  logic [TW-1:0]          touch_frame_count_r, touch_frame_count_nxt;

  logic [LENGTH_BITS-1:0] pos;
  logic [31:0]            pos_w;
  logic [31:0]            len_w;
  logic [TW-1:0]          frames_w;    // frame count seen by this byte
  logic [MAX_TOUCH_FRAMES-1:0] lift_hit;
  logic [7:0]             result;

  // A first byte restarts the report at position 0 with a fresh length.
  always_comb begin
    if (s1_first_r) begin
      pos                = '0;
      held_length_nxt    = s1_len_r;
      rewrite_active_nxt = (s1_data_r == REPORT_TAG) &&
                           (32'(s1_len_r) >= MIN_LENGTH);
      frames_w           = '0;
    end else begin
      pos                = byte_position_r;
      held_length_nxt    = held_length_r;
      rewrite_active_nxt = rewrite_active_r;
      frames_w           = touch_frame_count_r;
    end
  end

  assign pos_w = 32'(pos);
  assign len_w = 32'(held_length_nxt);

  // Position saturates so an endless stream never wraps back into a report.
  assign byte_position_nxt = (pos < POS_MAX) ? pos + 1'b1 : pos;

  // Contact bytes of frame m: 37+9m and 41+9m, for counted frames that fit.
  always_comb begin
    for (int m = 0; m < MAX_TOUCH_FRAMES; m++) begin
      lift_hit[m] = (32'(frames_w) > m) &&
                    (CONTACT_B + FRAME_STRIDE * m < len_w) &&
                    ((pos_w == CONTACT_A + FRAME_STRIDE * m) ||
                     (pos_w == CONTACT_B + FRAME_STRIDE * m));
    end
  end

  // Byte rewrite mux
  always_comb begin
    result                = s1_data_r;
    touch_frame_count_nxt = frames_w;
    if (rewrite_active_nxt && (pos_w < len_w)) begin
      if (pos_w >= STICK_FIRST && pos_w <= STICK_LAST) begin
        result = STICK_CENTER;
      end else if (pos_w == HAT_POS) begin
        result = HAT_NEUTRAL;
      end else if (pos_w == BTN_HI_POS) begin
        result = BYTE_ZERO;
      end else if (pos_w == BTN_LO_POS) begin
        result = s1_data_r & BTN_KEEP;
      end else if (pos_w == TRIG_L_POS || pos_w == TRIG_R_POS ||
                   (pos_w >= GYRO_FIRST && pos_w <= GYRO_LAST)) begin
        result = BYTE_ZERO;
      end else if (pos_w == COUNT_POS) begin
        // count byte passes; its value, capped, sets the frames to lift
        touch_frame_count_nxt = (32'(s1_data_r) > MAX_TOUCH_FRAMES) ?
                                TW'(MAX_TOUCH_FRAMES) : TW'(s1_data_r);
      end else if (|lift_hit) begin
        result = s1_data_r | LIFT_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r     <= '0;
      rewrite_active_r    <= 1'b0;
      held_length_r       <= '0;
      touch_frame_count_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      byte_position_r     <= byte_position_nxt;
      rewrite_active_r    <= rewrite_active_nxt;
      held_length_r       <= held_length_nxt;
      touch_frame_count_r <= touch_frame_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic       out_valid_r;
  logic [7:0] out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_byte_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule
